@@ hdl/assert_macros.svh @@
// Assertion macros for the translator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TPT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define TPT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/tpt_pkg.sv @@
// Constants, types and state codes of the TLB page table translator
`default_nettype none

package tpt_pkg;

  localparam int TLB_ENTRIES = 16;
  localparam int PAGE_COUNT  = 256;
  localparam int FRAME_COUNT = 128;
  localparam int PAGE_BYTES  = 256;

  localparam int ADDR_W  = 16;
  localparam int PHYS_W  = 15;
  localparam int FPAGE_W = 8;
  localparam int CNT_W   = 32;

  localparam int PAGE_W  = $clog2(PAGE_COUNT);
  localparam int OFF_W   = $clog2(PAGE_BYTES);
  localparam int FRAME_W = $clog2(FRAME_COUNT);
  localparam int FREE_W  = $clog2(FRAME_COUNT + 1);
  localparam int OUT_FRAME_W = 7;

  localparam int OUT_DATA_W = 96;
  localparam int OUT_USER_W = 3;

  typedef logic [PAGE_W-1:0]  page_t;
  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [OFF_W-1:0]   offset_t;

  typedef struct packed {
    logic   valid;
    page_t  page;
    frame_t frame;
  } tlb_entry_t;

  typedef struct packed {
    logic   hit;
    frame_t frame;
  } tlb_match_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } tpt_state_t;

endpackage

`default_nettype wire

@@ hdl/tpt_tlb_cell.sv @@
// One TLB cell: holds an entry, shifts it on fill, and extends the search chain
`default_nettype none

module tpt_tlb_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               shift_en,
  input  wire tpt_pkg::page_t     lookup_page,
  input  wire tpt_pkg::tlb_entry_t entry_in,
  output tpt_pkg::tlb_entry_t     entry_out,
  input  wire tpt_pkg::tlb_match_t match_in,
  output tpt_pkg::tlb_match_t     match_out
);
  import tpt_pkg::*;

  logic   valid_r;
  page_t  page_r;
  frame_t frame_r;
  logic   here;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift_en) begin
      valid_r <= entry_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      page_r  <= entry_in.page;
      frame_r <= entry_in.frame;
    end
  end

  always_comb begin
    here            = valid_r && (page_r == lookup_page);
    match_out.hit   = match_in.hit | here;
    match_out.frame = here ? frame_r : match_in.frame;
    entry_out.valid = valid_r;
    entry_out.page  = page_r;
    entry_out.frame = frame_r;
  end

endmodule

`default_nettype wire

@@ hdl/tpt_page_table.sv @@
// Page table: frame memory with registered read and per-page resident bits
`default_nettype none

module tpt_page_table (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            rd_en,
  input  wire tpt_pkg::page_t  rd_page,
  output tpt_pkg::frame_t      rd_frame,
  output logic                 rd_valid,
  input  wire logic            wr_en,
  input  wire tpt_pkg::page_t  wr_page,
  input  wire tpt_pkg::frame_t wr_frame
);
  import tpt_pkg::*;

  frame_t                  mem [PAGE_COUNT];
  logic [PAGE_COUNT-1:0]   resident_r;
  frame_t                  rd_frame_r;
  logic                    rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_page] <= wr_frame;
    end
    if (rd_en) begin
      rd_frame_r <= mem[rd_page];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resident_r <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        resident_r[wr_page] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= resident_r[rd_page];
      end
    end
  end

  assign rd_frame = rd_frame_r;
  assign rd_valid = rd_valid_r;

endmodule

`default_nettype wire

@@ hdl/tlb_page_table_translator.sv @@
// Top level of the TLB and page table address translator
//
// Input channel in_*: one 16-bit logical address per request (page in the
// upper byte, offset in the lower byte). Output channel out_*: one result per
// request with physical address, frame, fault page and the running hit and
// fault counts in out_tdata, and the hit, fault and no-free-frame flags in
// out_tuser.
// Each request is accepted in ST_IDLE, where the page table memory is read;
// in ST_LOOKUP the row of TLB cells is searched, the frame resolved, the
// page table written back and a new entry shifted into the TLB once the
// output register is free. The registered result appears in the cycle after
// that; the next request is taken only after ST_LOOKUP completes, so a new
// request is never accepted while the last one is still being looked up.
// Reset empties the TLB, marks every page non-resident and clears the free
// frame counter and both totals; no clearing pass is needed.
// While the receiver stalls, the result holds in the output register; one
// more request is taken and held in ST_LOOKUP until the register frees.
`default_nettype none
`include "assert_macros.svh"

module tlb_page_table_translator (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // [15:0] logical_addr
  input  wire logic [tpt_pkg::ADDR_W-1:0]         in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [14:0] physical_addr, [21:15] frame_number, [29:22] fault_page,
  // [61:30] hit_total, [93:62] fault_total, [95:94] zero
  output logic [tpt_pkg::OUT_DATA_W-1:0]          out_tdata,
  // [0] tlb_hit, [1] page_fault, [2] no_free_frame
  output logic [tpt_pkg::OUT_USER_W-1:0]          out_tuser
);
  import tpt_pkg::*;

  tpt_state_t state_r, state_nxt;

  page_t   page_r;
  offset_t offset_r;
  logic    in_accept;
  logic    load_out;

  tlb_entry_t entry_chain [TLB_ENTRIES+1];
  tlb_match_t match_chain [TLB_ENTRIES+1];
  logic       tlb_shift;

  frame_t pt_frame;
  logic   pt_valid;
  logic   pt_write;

  logic [FREE_W-1:0] next_free_r, next_free_nxt;
  logic [CNT_W-1:0]  hit_cnt_r, hit_cnt_nxt;
  logic [CNT_W-1:0]  fault_cnt_r, fault_cnt_nxt;

  logic   hit, fault, full, have_frame;
  frame_t frame;

  logic                   out_valid_r;
  logic [PHYS_W-1:0]      phys_r;
  logic [OUT_FRAME_W-1:0] oframe_r;
  logic [FPAGE_W-1:0]     fpage_r;
  logic                   hit_r, fault_r, full_r;

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      page_r   <= in_tdata[OFF_W +: PAGE_W];
      offset_r <= in_tdata[OFF_W-1:0];
    end
  end

  tpt_page_table u_page_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_accept),
    .rd_page  (in_tdata[OFF_W +: PAGE_W]),
    .rd_frame (pt_frame),
    .rd_valid (pt_valid),
    .wr_en    (pt_write),
    .wr_page  (page_r),
    .wr_frame (frame)
  );

  assign entry_chain[0].valid = 1'b1;
  assign entry_chain[0].page  = page_r;
  assign entry_chain[0].frame = frame;
  assign match_chain[0].hit   = 1'b0;
  assign match_chain[0].frame = '0;

  for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
    tpt_tlb_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .shift_en    (tlb_shift),
      .lookup_page (page_r),
      .entry_in    (entry_chain[i]),
      .entry_out   (entry_chain[i+1]),
      .match_in    (match_chain[i]),
      .match_out   (match_chain[i+1])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    load_out      = 1'b0;
    hit           = match_chain[TLB_ENTRIES].hit;
    fault         = 1'b0;
    full          = 1'b0;
    have_frame    = 1'b0;
    frame         = '0;
    pt_write      = 1'b0;
    tlb_shift     = 1'b0;
    next_free_nxt = next_free_r;
    hit_cnt_nxt   = hit_cnt_r;
    fault_cnt_nxt = fault_cnt_r;

    if (hit) begin
      frame       = match_chain[TLB_ENTRIES].frame;
      have_frame  = 1'b1;
      hit_cnt_nxt = hit_cnt_r + 1'b1;
    end else if (pt_valid) begin
      frame      = pt_frame;
      have_frame = 1'b1;
    end else begin
      fault         = 1'b1;
      fault_cnt_nxt = fault_cnt_r + 1'b1;
      if (next_free_r == FREE_W'(FRAME_COUNT)) begin
        full = 1'b1;
      end else begin
        frame         = next_free_r[FRAME_W-1:0];
        have_frame    = 1'b1;
        next_free_nxt = next_free_r + 1'b1;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          pt_write  = fault && !full;
          tlb_shift = !hit && have_frame;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      next_free_r <= '0;
      hit_cnt_r   <= '0;
      fault_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        next_free_r <= next_free_nxt;
        hit_cnt_r   <= hit_cnt_nxt;
        fault_cnt_r <= fault_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      phys_r   <= have_frame ? PHYS_W'({frame, offset_r}) : '0;
      oframe_r <= OUT_FRAME_W'(frame);
      fpage_r  <= fault ? FPAGE_W'(page_r) : '0;
      hit_r    <= hit;
      fault_r  <= fault;
      full_r   <= full;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, fault_cnt_r, hit_cnt_r, fpage_r, oframe_r, phys_r};
  assign out_tuser  = {full_r, fault_r, hit_r};

  `TPT_ASSERT_IMP(a_full_is_fault, clk, rst_n, out_tvalid && out_tuser[2], out_tuser[1], "no free frame without fault")
  `TPT_ASSERT_IMP(a_hit_xor_fault, clk, rst_n, out_tvalid, !(out_tuser[0] && out_tuser[1]), "hit and fault together")
  `TPT_ASSERT_IMP(a_free_bound, clk, rst_n, 1'b1, next_free_r <= FREE_W'(FRAME_COUNT), "free frame count overrun")
  `TPT_ASSERT_NXT(a_accept_lookup, clk, rst_n, in_accept, state_r == ST_LOOKUP, "accept did not start lookup")

endmodule

`default_nettype wire
